// ----- hdl/ras_pkg.sv -----
// Shared types, constants and microcode program of the room allocation scheduler.
package ras_pkg;

  localparam int MAX_ROOMS   = 16;
  localparam int TIME_BITS   = 40;
  localparam int ROOM_BITS   = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;
  localparam int CFG_BITS    = 5;
  localparam int ROOMS_RESET = 16;
  localparam int COUNT_BITS  = 32;
  localparam int REQ_BITS    = 32;
  localparam int OUT_ROOM_BITS = 4;
  localparam int OUT_TIME_BITS = 40;

  typedef struct packed {
    logic [REQ_BITS-1:0] start_time;
    logic [REQ_BITS-1:0] end_time;
    logic                last_request;
  } req_t;

  typedef struct packed {
    logic [OUT_ROOM_BITS-1:0] assigned_room;
    logic [OUT_TIME_BITS-1:0] actual_start;
    logic [OUT_TIME_BITS-1:0] actual_end;
    logic                     was_delayed;
    logic [OUT_ROOM_BITS-1:0] most_booked_room;
    logic [COUNT_BITS-1:0]    most_booked_count;
  } rsp_t;

  typedef logic [1:0] step_t;

  localparam step_t STEP_ACCEPT = 2'd0;
  localparam step_t STEP_SCAN   = 2'd1;
  localparam step_t STEP_CALC   = 2'd2;
  localparam step_t STEP_EMIT   = 2'd3;

  typedef enum logic [1:0] {
    COND_NEVER     = 2'd0,
    COND_NO_INPUT  = 2'd1,
    COND_SCAN_MORE = 2'd2,
    COND_OUT_BUSY  = 2'd3
  } cond_t;

  typedef struct packed {
    logic  accept;
    logic  scan;
    logic  calc;
    logic  emit;
    cond_t cond;
    step_t jump;
    step_t next;
  } ctrl_t;

  typedef struct packed {
    logic req_present;
    logic scan_more;
    logic out_busy;
  } status_t;

  // Program: wait for a request, scan rooms, form times, write back and emit.
  function automatic ctrl_t ucode(input step_t step);
    ctrl_t w;
    w = '0;
    unique case (step)
      STEP_ACCEPT: begin
        w.accept = 1'b1;
        w.cond   = COND_NO_INPUT;
        w.jump   = STEP_ACCEPT;
        w.next   = STEP_SCAN;
      end
      STEP_SCAN: begin
        w.scan = 1'b1;
        w.cond = COND_SCAN_MORE;
        w.jump = STEP_SCAN;
        w.next = STEP_CALC;
      end
      STEP_CALC: begin
        w.calc = 1'b1;
        w.cond = COND_NEVER;
        w.jump = STEP_CALC;
        w.next = STEP_EMIT;
      end
      STEP_EMIT: begin
        w.emit = 1'b1;
        w.cond = COND_OUT_BUSY;
        w.jump = STEP_EMIT;
        w.next = STEP_ACCEPT;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- hdl/room_allocation_scheduler_core.sv -----
// Top level of the room allocation scheduler: microcoded sequencer plus datapath.
// A request passes the scan, calc and emit steps in order; emit registers the result and waits
// while the output register is stalled. The next request is taken only after the emit, and the
// scan checks one room per cycle over the room stores.
// A waiting result sits in the output register while the next request is taken and scanned.
// Reset (rst, synchronous): rooms_in_use returns to 16, all rooms free, counts zero.
module room_allocation_scheduler_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [ras_pkg::CFG_BITS-1:0]  wr_data,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  ras_pkg::req_t                 req,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output ras_pkg::rsp_t                 rsp
);

  ras_pkg::step_t   step;
  ras_pkg::ctrl_t   ctrl;
  ras_pkg::status_t status;

  // Take a request only in the accept step of the program.
  assign req_stall = !ctrl.accept;

  // Sequencer: step counter walks the control program, jumping on datapath status.
  ras_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .step   (step),
    .ctrl   (ctrl)
  );

  // Datapath: scan rooms, saturate times, update stores, hold the result for transfer.
  ras_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .status    (status),
    .wr_en     (wr_en),
    .wr_data   (wr_data),
    .req_valid (req_valid),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // A request transfer moves the program on to the scan.
  a_accept_scan: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> (step == ras_pkg::STEP_SCAN))
    else $error("request transfer not followed by scan");

  // A new result only comes out of the emit step.
  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(step) == ras_pkg::STEP_EMIT))
    else $error("result appeared outside emit step");

  // Emit with a free output register always loads a result.
  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    (step == ras_pkg::STEP_EMIT && !status.out_busy) |=>
      (rsp_valid && step == ras_pkg::STEP_ACCEPT))
    else $error("emit did not load result");

endmodule

// ----- hdl/ras_sequencer.sv -----
// Step counter and control-word lookup of the room allocation scheduler.
module ras_sequencer (
  input  logic              clk,
  input  logic              rst,
  input  ras_pkg::status_t  status,
  output ras_pkg::step_t    step,
  output ras_pkg::ctrl_t    ctrl
);

  ras_pkg::step_t step_next;
  logic           take_jump;

  assign ctrl = ras_pkg::ucode(step);

  always_comb begin
    case (ctrl.cond)
      ras_pkg::COND_NEVER:     take_jump = 1'b0;
      ras_pkg::COND_NO_INPUT:  take_jump = !status.req_present;
      ras_pkg::COND_SCAN_MORE: take_jump = status.scan_more;
      ras_pkg::COND_OUT_BUSY:  take_jump = status.out_busy;
      default:                 take_jump = 1'b0;
    endcase
    step_next = take_jump ? ctrl.jump : ctrl.next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ras_pkg::STEP_ACCEPT;
    end else begin
      step <= step_next;
    end
  end

endmodule

// ----- hdl/ras_datapath.sv -----
// Room stores, scan, time arithmetic and result register of the room allocation scheduler.
module ras_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  ras_pkg::ctrl_t                ctrl,
  output ras_pkg::status_t              status,
  input  logic                          wr_en,
  input  logic [ras_pkg::CFG_BITS-1:0]  wr_data,
  input  logic                          req_valid,
  input  ras_pkg::req_t                 req,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output ras_pkg::rsp_t                 rsp
);

  localparam int TB = ras_pkg::TIME_BITS;
  localparam int RB = ras_pkg::ROOM_BITS;
  localparam int CB = ras_pkg::COUNT_BITS;
  localparam int SUM_BITS = ((TB > ras_pkg::REQ_BITS) ? TB : ras_pkg::REQ_BITS) + 1;
  localparam logic [TB-1:0] TIME_MAX  = '1;
  localparam logic [CB-1:0] COUNT_MAX = '1;

  logic [ras_pkg::CFG_BITS-1:0] rooms_in_use;

  logic [TB-1:0] busy  [ras_pkg::MAX_ROOMS];
  logic [CB-1:0] count [ras_pkg::MAX_ROOMS];
  logic [ras_pkg::MAX_ROOMS-1:0] room_valid;

  logic [RB-1:0]           best_room;
  logic [CB-1:0]           best_count;

  logic [TB-1:0]           start_r;
  logic [ras_pkg::REQ_BITS-1:0] len_r;
  logic                    last_r;
  logic [RB-1:0]           scan_idx;
  logic                    found;
  logic [RB-1:0]           room_r;
  logic [TB-1:0]           min_val;
  logic [RB-1:0]           min_idx;
  logic [TB-1:0]           act_start;
  logic [TB-1:0]           act_end;

  logic [RB-1:0]           last_idx;
  logic [63:0]             start_wide;
  logic [TB-1:0]           start_sat;
  logic [ras_pkg::REQ_BITS-1:0] len_in;
  logic [TB-1:0]           entry;
  logic                    entry_free;
  logic [TB-1:0]           calc_start;
  logic [SUM_BITS-1:0]     calc_sum;
  logic [TB-1:0]           calc_end;
  logic [CB-1:0]           cur_count;
  logic [CB-1:0]           new_count;
  logic                    new_best;
  logic                    out_free;
  logic                    accept;
  logic                    emit_fire;

  // Clamp the configured room count to one .. MAX_ROOMS.
  always_comb begin
    if (rooms_in_use == '0) begin
      last_idx = '0;
    end else if (int'(rooms_in_use) > ras_pkg::MAX_ROOMS) begin
      last_idx = RB'(ras_pkg::MAX_ROOMS - 1);
    end else begin
      last_idx = RB'(rooms_in_use - ras_pkg::CFG_BITS'(1));
    end
  end

  always_comb begin
    start_wide = 64'(req.start_time);
    start_sat  = (start_wide > 64'(TIME_MAX)) ? TIME_MAX : TB'(start_wide);
    len_in     = (req.end_time >= req.start_time) ? req.end_time - req.start_time : '0;
  end

  assign entry      = room_valid[scan_idx] ? busy[scan_idx] : '0;
  assign entry_free = (entry <= start_r);

  always_comb begin
    calc_start = found ? start_r : min_val;
    calc_sum   = SUM_BITS'(calc_start) + SUM_BITS'(len_r);
    calc_end   = (calc_sum > SUM_BITS'(TIME_MAX)) ? TIME_MAX : TB'(calc_sum);
  end

  always_comb begin
    cur_count = room_valid[room_r] ? count[room_r] : '0;
    new_count = (cur_count == COUNT_MAX) ? cur_count : cur_count + CB'(1);
    new_best  = (new_count > best_count) || ((new_count == best_count) && (room_r < best_room));
  end

  assign out_free  = !rsp_valid || !rsp_stall;
  assign accept    = ctrl.accept && req_valid;
  assign emit_fire = ctrl.emit && out_free;

  assign status.req_present = req_valid;
  assign status.scan_more   = !entry_free && (scan_idx != last_idx);
  assign status.out_busy    = !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      rooms_in_use <= ras_pkg::CFG_BITS'(ras_pkg::ROOMS_RESET);
    end else if (wr_en) begin
      rooms_in_use <= wr_data;
    end
  end

  // Request registers and scan bookkeeping.
  always_ff @(posedge clk) begin
    if (accept) begin
      start_r  <= start_sat;
      len_r    <= len_in;
      last_r   <= req.last_request;
      scan_idx <= '0;
      found    <= 1'b0;
    end
    if (ctrl.scan) begin
      if (entry_free) begin
        found  <= 1'b1;
        room_r <= scan_idx;
      end
      if ((scan_idx == '0) || (entry < min_val)) begin
        min_val <= entry;
        min_idx <= scan_idx;
      end
      scan_idx <= scan_idx + RB'(1);
    end
    if (ctrl.calc) begin
      if (!found) begin
        room_r <= min_idx;
      end
      act_start <= calc_start;
      act_end   <= calc_end;
    end
  end

  // Room stores: write back the chosen room.
  always_ff @(posedge clk) begin
    if (emit_fire) begin
      busy[room_r]  <= act_end;
      count[room_r] <= new_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      room_valid <= '0;
      best_room  <= '0;
      best_count <= '0;
    end else if (emit_fire) begin
      if (last_r) begin
        room_valid <= '0;
        best_room  <= '0;
        best_count <= '0;
      end else begin
        room_valid[room_r] <= 1'b1;
        if (new_best) begin
          best_room  <= room_r;
          best_count <= new_count;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (emit_fire) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      rsp.assigned_room     <= ras_pkg::OUT_ROOM_BITS'(room_r);
      rsp.actual_start      <= ras_pkg::OUT_TIME_BITS'(act_start);
      rsp.actual_end        <= ras_pkg::OUT_TIME_BITS'(act_end);
      rsp.was_delayed       <= !found;
      rsp.most_booked_room  <= ras_pkg::OUT_ROOM_BITS'(new_best ? room_r : best_room);
      rsp.most_booked_count <= new_best ? new_count : best_count;
    end
  end

endmodule
